// ===== design/mt64_pkg.sv =====
package mt64_pkg;

   localparam int STATE_WORDS   = 312;
   localparam int MIDDLE_OFFSET = 156;
   localparam int INDEX_BITS    = 9;

   localparam logic [63:0] TWIST_MATRIX = 64'hB5026F5AA96619E9;
   localparam logic [63:0] HIGH_MASK    = 64'hFFFFFFFF80000000;
   localparam logic [63:0] LOW_MASK     = 64'h000000007FFFFFFF;
   localparam logic [63:0] DEFAULT_SEED = 64'd5489;
   localparam logic [63:0] INIT_MULT    = 64'h5851F42D4C957F2D;

   localparam logic [63:0] TEMPER_B = 64'h5555555555555555;
   localparam logic [63:0] TEMPER_C = 64'h71D67FFFEDA60000;
   localparam logic [63:0] TEMPER_D = 64'hFFF7EEE000000000;

   localparam logic [0:0] CMD_SEED = 1'b0;
   localparam logic [0:0] CMD_DRAW = 1'b1;

   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [63:0]           word_type;

   function automatic word_type temper(input word_type w);
      word_type y;
      y = w;
      y = y ^ ((y >> 29) & TEMPER_B);
      y = y ^ ((y << 17) & TEMPER_C);
      y = y ^ ((y << 37) & TEMPER_D);
      y = y ^ (y >> 43);
      return y;
   endfunction

   function automatic word_type seed_mix(input word_type w);
      return w ^ (w >> 62);
   endfunction

endpackage

// ===== design/mersenne_twister_64_generator_top.sv =====
// 64-bit Mersenne Twister generator with a stream input and a stream output.
// An input item carries a command in req_tuser and a seed in req_tdata.
// A seed command (req_tuser low) fills the 312-word table and gives no result.
// A draw command (req_tuser high) returns one tempered word on rsp_tdata.
// One item is worked on at a time; req_tready is high only while the block idles.
// A seed steps through four states per table word: one 32x32 multiplier is reused in
// three of them, and the fourth adds the partial products and writes the table.
// A draw, when unused words remain, is one table read and one tempering step.
// When the table is used up, a draw first regenerates it with a read state and a write
// state per word, limited by the two read ports and one write port of the table memory.
// The first draw after reset seeds the table with 5489 before regenerating it.
// Reset clears the control state and marks the table as never seeded; the table
// memory itself keeps no reset value.
// Results wait in an output register. The next item is accepted while a result
// waits, but a draw does not finish until the previous result has been taken.
module mersenne_twister_64_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // Fields from bit 0: seed[63:0].
   input  logic [0:0]  req_tuser,   // Fields from bit 0: command[0].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // Fields from bit 0: random_value[63:0].
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SEED_M0 = 4'd1;
   localparam logic [3:0] ST_SEED_M1 = 4'd2;
   localparam logic [3:0] ST_SEED_M2 = 4'd3;
   localparam logic [3:0] ST_SEED_WR = 4'd4;
   localparam logic [3:0] ST_TW_PRE  = 4'd5;
   localparam logic [3:0] ST_TW_RD   = 4'd6;
   localparam logic [3:0] ST_TW_WR   = 4'd7;
   localparam logic [3:0] ST_DR_RD   = 4'd8;
   localparam logic [3:0] ST_DR_OUT  = 4'd9;

   localparam mt64_pkg::index_type LAST_IDX   = mt64_pkg::index_type'(mt64_pkg::STATE_WORDS - 1);
   localparam mt64_pkg::index_type FULL_IDX   = mt64_pkg::index_type'(mt64_pkg::STATE_WORDS);
   localparam mt64_pkg::index_type UNSEEDED   = mt64_pkg::index_type'(mt64_pkg::STATE_WORDS + 1);
   localparam mt64_pkg::index_type MID_OFFSET = mt64_pkg::index_type'(mt64_pkg::MIDDLE_OFFSET);

   mt64_pkg::word_type table_mem [mt64_pkg::STATE_WORDS];

   logic [3:0]          state_ff, state_in;
   mt64_pkg::index_type idx_ff, idx_in;
   mt64_pkg::index_type rd_idx_ff, rd_idx_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mt64_pkg::word_type  rsp_data_ff, rsp_data_in;
   mt64_pkg::word_type  mix_ff, mix_in;
   mt64_pkg::word_type  cur_ff, cur_in;
   mt64_pkg::word_type  prod_ff, prod_in;
   mt64_pkg::word_type  lo_ff, lo_in;
   logic [31:0]         cross_ff, cross_in;
   mt64_pkg::word_type  rd_a_ff, rd_b_ff;

   mt64_pkg::index_type addr_a, addr_b, waddr;
   mt64_pkg::index_type nxt_idx, mid_idx;
   logic                wen;
   mt64_pkg::word_type  wdata;
   logic [31:0]         mul_a, mul_b;
   mt64_pkg::word_type  seed_word, twist_y, twist_v, new_seed;
   logic [31:0]         cross_sum;
   logic                out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign nxt_idx = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign mid_idx = (idx_ff < MID_OFFSET) ? idx_ff + MID_OFFSET : idx_ff - MID_OFFSET;

   assign cross_sum = cross_ff + prod_ff[31:0];
   assign seed_word = lo_ff + {cross_sum, 32'b0} + {{(64 - mt64_pkg::INDEX_BITS){1'b0}}, idx_ff};

   assign twist_y = (cur_ff & mt64_pkg::HIGH_MASK) | (rd_a_ff & mt64_pkg::LOW_MASK);
   assign twist_v = rd_b_ff ^ (twist_y >> 1) ^ (twist_y[0] ? mt64_pkg::TWIST_MATRIX : '0);

   assign new_seed = (req_tuser == mt64_pkg::CMD_SEED) ? req_tdata : mt64_pkg::DEFAULT_SEED;

   always_comb begin
      case (state_ff)
         ST_SEED_M1: begin
            mul_a = mix_ff[31:0];
            mul_b = mt64_pkg::INIT_MULT[63:32];
         end
         ST_SEED_M2: begin
            mul_a = mix_ff[63:32];
            mul_b = mt64_pkg::INIT_MULT[31:0];
         end
         default: begin
            mul_a = mix_ff[31:0];
            mul_b = mt64_pkg::INIT_MULT[31:0];
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mix_in       = mix_ff;
      cur_in       = cur_ff;
      prod_in      = {32'b0, mul_a} * {32'b0, mul_b};
      lo_in        = lo_ff;
      cross_in     = cross_ff;
      addr_a       = idx_ff;
      addr_b       = mid_idx;
      wen          = 1'b0;
      waddr        = idx_ff;
      wdata        = seed_word;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == mt64_pkg::CMD_SEED || rd_idx_ff == UNSEEDED) begin
                  wen      = 1'b1;
                  waddr    = '0;
                  wdata    = new_seed;
                  mix_in   = mt64_pkg::seed_mix(new_seed);
                  idx_in   = mt64_pkg::index_type'(1);
                  pend_in  = (req_tuser == mt64_pkg::CMD_DRAW);
                  state_in = ST_SEED_M0;
               end else if (rd_idx_ff >= FULL_IDX) begin
                  idx_in   = '0;
                  state_in = ST_TW_PRE;
               end else begin
                  state_in = ST_DR_RD;
               end
            end
         end
         ST_SEED_M0: begin
            state_in = ST_SEED_M1;
         end
         ST_SEED_M1: begin
            lo_in    = prod_ff;
            state_in = ST_SEED_M2;
         end
         ST_SEED_M2: begin
            cross_in = prod_ff[31:0];
            state_in = ST_SEED_WR;
         end
         ST_SEED_WR: begin
            wen    = 1'b1;
            mix_in = mt64_pkg::seed_mix(seed_word);
            if (idx_ff == LAST_IDX) begin
               rd_idx_in = FULL_IDX;
               idx_in    = '0;
               state_in  = pend_ff ? ST_TW_PRE : ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SEED_M0;
            end
         end
         ST_TW_PRE: begin
            addr_a   = '0;
            state_in = ST_TW_RD;
         end
         ST_TW_RD: begin
            addr_a = nxt_idx;
            if (idx_ff == '0) begin
               cur_in = rd_a_ff;
            end
            state_in = ST_TW_WR;
         end
         ST_TW_WR: begin
            wen    = 1'b1;
            wdata  = twist_v;
            cur_in = rd_a_ff;
            if (idx_ff == LAST_IDX) begin
               rd_idx_in = '0;
               idx_in    = '0;
               state_in  = ST_DR_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_TW_RD;
            end
         end
         ST_DR_RD: begin
            addr_a   = rd_idx_ff;
            state_in = ST_DR_OUT;
         end
         ST_DR_OUT: begin
            addr_a = rd_idx_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mt64_pkg::temper(rd_a_ff);
               rd_idx_in    = rd_idx_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         table_mem[waddr] <= wdata;
      end
      rd_a_ff <= table_mem[addr_a];
      rd_b_ff <= table_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= UNSEEDED;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      mix_ff      <= mix_in;
      cur_ff      <= cur_in;
      prod_ff     <= prod_in;
      lo_ff       <= lo_in;
      cross_ff    <= cross_in;
   end

endmodule

// ===== dv/mersenne_twister_64_generator_top_tb.sv =====
module mersenne_twister_64_generator_top_tb;

   typedef struct {
      logic [0:0]         command;
      mt64_pkg::word_type seed;
      bit                 wait_drain;
   } command_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [0:0]  req_tuser = mt64_pkg::CMD_DRAW;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   command_item_type   command_queue[$];
   mt64_pkg::word_type expected_words[$];
   int                 total_items;
   int                 items_driven = 0;
   int                 draws_predicted = 0;
   int                 results_checked = 0;
   int                 error_count = 0;
   int                 hold_left = 0;
   bit                 first_hold_done = 1'b0;
   bit                 second_hold_done = 1'b0;

   mt64_pkg::word_type model_table [mt64_pkg::STATE_WORDS];
   int unsigned        model_next = mt64_pkg::STATE_WORDS + 1;

   mersenne_twister_64_generator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void fill_table(input mt64_pkg::word_type s);
      model_table[0] = s;
      for (int k = 1; k < mt64_pkg::STATE_WORDS; k++) begin
         model_table[k] = mt64_pkg::INIT_MULT
                          * (model_table[k-1] ^ (model_table[k-1] >> 62))
                          + mt64_pkg::word_type'(k);
      end
      model_next = mt64_pkg::STATE_WORDS;
   endfunction

   function automatic void twist_table();
      mt64_pkg::word_type y;
      mt64_pkg::word_type v;
      for (int k = 0; k < mt64_pkg::STATE_WORDS; k++) begin
         y = (model_table[k] & mt64_pkg::HIGH_MASK)
             | (model_table[(k + 1) % mt64_pkg::STATE_WORDS] & mt64_pkg::LOW_MASK);
         v = model_table[(k + mt64_pkg::MIDDLE_OFFSET) % mt64_pkg::STATE_WORDS] ^ (y >> 1);
         if (y[0]) begin
            v = v ^ mt64_pkg::TWIST_MATRIX;
         end
         model_table[k] = v;
      end
      model_next = 0;
   endfunction

   function automatic mt64_pkg::word_type scramble_word(input mt64_pkg::word_type w);
      mt64_pkg::word_type t;
      t = w ^ ((w >> 29) & mt64_pkg::TEMPER_B);
      t = t ^ ((t << 17) & mt64_pkg::TEMPER_C);
      t = t ^ ((t << 37) & mt64_pkg::TEMPER_D);
      return t ^ (t >> 43);
   endfunction

   function automatic void predict_command(input logic [0:0] command,
                                           input mt64_pkg::word_type seed);
      if (command == mt64_pkg::CMD_SEED) begin
         fill_table(seed);
      end else begin
         if (model_next == mt64_pkg::STATE_WORDS + 1) begin
            fill_table(mt64_pkg::DEFAULT_SEED);
         end
         if (model_next >= mt64_pkg::STATE_WORDS) begin
            twist_table();
         end
         expected_words.push_back(scramble_word(model_table[model_next]));
         model_next++;
         draws_predicted++;
      end
   endfunction

   // The run has three stretches: a slow receiver, then a slow sender, then no idling.
   function automatic int idle_pct(input bit receiver);
      if (items_driven < total_items / 3) begin
         return receiver ? 67 : 14;
      end else if (items_driven < 2 * total_items / 3) begin
         return receiver ? 14 : 67;
      end
      return 0;
   endfunction

   task automatic queue_command(input logic [0:0] command, input mt64_pkg::word_type seed,
                                input bit wait_drain);
      command_item_type it;
      it.command    = command;
      it.seed       = seed;
      it.wait_drain = wait_drain;
      command_queue.push_back(it);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_command(req_tuser, req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (command_queue.size() != 0 &&
                !(command_queue[0].wait_drain && draws_predicted != results_checked) &&
                $urandom_range(99) >= idle_pct(1'b0)) begin
               req_tvalid   <= 1'b1;
               req_tuser    <= command_queue[0].command;
               req_tdata    <= command_queue[0].seed;
               items_driven <= items_driven + 1;
               void'(command_queue.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Two long hold-offs let the block fill up and stall its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!first_hold_done && results_checked >= 60) begin
         first_hold_done <= 1'b1;
         rsp_tready      <= 1'b0;
         hold_left       <= 400;
      end else if (!second_hold_done && results_checked >= 700) begin
         second_hold_done <= 1'b1;
         rsp_tready       <= 1'b0;
         hold_left        <= 400;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("random_value: expected no item, got %h", rsp_tdata);
            error_count++;
         end else begin
            if (rsp_tdata !== expected_words[0]) begin
               $error("random_value: expected %h, got %h", expected_words[0], rsp_tdata);
               error_count++;
            end
            void'(expected_words.pop_front());
            results_checked <= results_checked + 1;
         end
      end
   end

   initial begin
      mt64_pkg::word_type s;
      int                 run_len;

      // The first draws arrive before any seed, so the block must seed itself.
      queue_command(mt64_pkg::CMD_DRAW, '1, 1'b0);
      for (int n = 0; n < 3; n++) begin
         queue_command(mt64_pkg::CMD_DRAW, {$urandom, $urandom}, 1'b0);
      end
      queue_command(mt64_pkg::CMD_SEED, '0, 1'b1);
      queue_command(mt64_pkg::CMD_DRAW, '0, 1'b0);
      queue_command(mt64_pkg::CMD_DRAW, '1, 1'b0);
      queue_command(mt64_pkg::CMD_SEED, '1, 1'b0);
      queue_command(mt64_pkg::CMD_DRAW, {$urandom, $urandom}, 1'b0);
      queue_command(mt64_pkg::CMD_DRAW, {$urandom, $urandom}, 1'b0);
      queue_command(mt64_pkg::CMD_SEED, mt64_pkg::DEFAULT_SEED, 1'b0);
      queue_command(mt64_pkg::CMD_DRAW, {$urandom, $urandom}, 1'b0);
      queue_command(mt64_pkg::CMD_SEED, 64'h8000000000000000, 1'b0);
      queue_command(mt64_pkg::CMD_SEED, 64'd1, 1'b0);
      queue_command(mt64_pkg::CMD_DRAW, {$urandom, $urandom}, 1'b0);
      queue_command(mt64_pkg::CMD_DRAW, {$urandom, $urandom}, 1'b0);
      queue_command(mt64_pkg::CMD_SEED, {$urandom, $urandom}, 1'b1);
      queue_command(mt64_pkg::CMD_DRAW, {$urandom, $urandom}, 1'b0);

      // Runs of draws, some long enough to use up the table more than once.
      while (command_queue.size() < 1500) begin
         run_len = ($urandom_range(3) == 0) ? $urandom_range(300, 700) : $urandom_range(1, 40);
         if (run_len > 1500 - command_queue.size()) begin
            run_len = 1500 - command_queue.size();
         end
         if ($urandom_range(3) != 0) begin
            if ($urandom_range(3) == 0) begin
               s = mt64_pkg::word_type'($urandom_range(10000));
            end else begin
               s = {$urandom, $urandom};
            end
            queue_command(mt64_pkg::CMD_SEED, s, $urandom_range(4) == 0);
         end
         for (int n = 0; n < run_len; n++) begin
            queue_command(mt64_pkg::CMD_DRAW, {$urandom, $urandom}, 1'b0);
         end
      end
      total_items = command_queue.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (command_queue.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
      while (draws_predicted != results_checked) begin
         @(posedge clock);
      end
      repeat (1400) @(posedge clock);

      if (error_count == 0 && expected_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
design/mt64_pkg.sv
design/mersenne_twister_64_generator_top.sv
dv/mersenne_twister_64_generator_top_tb.sv
